// ----- hw/rtl/rhrs_pkg.sv -----
// ----------------------------------------------------------------------------
// rhrs_pkg
// Shared types and fixed widths for the RGB hue range shift pipeline.
// ----------------------------------------------------------------------------
package rhrs_pkg;

  localparam int unsigned PIX_W = 8;
  localparam int unsigned CFG_W = 9;
  localparam int unsigned HUE_W = 13;
  localparam int unsigned SAT_W = 9;
  localparam int unsigned IDX_W = 2;

  localparam logic [IDX_W-1:0] CFG_HUE_LOW   = 2'd0;
  localparam logic [IDX_W-1:0] CFG_HUE_HIGH  = 2'd1;
  localparam logic [IDX_W-1:0] CFG_HUE_SHIFT = 2'd2;

  localparam logic [CFG_W-1:0] HUE_LOW_RST   = 9'd0;
  localparam logic [CFG_W-1:0] HUE_HIGH_RST  = 9'd360;
  localparam logic [CFG_W-1:0] HUE_SHIFT_RST = 9'd0;

  // which component is the maximum; blue wins ties, then green
  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_e;

  typedef struct packed {
    logic [PIX_W-1:0] mx;
    sector_e          sector;
    logic             neg;
    logic             c_zero;
    logic             mx_zero;
  } side_t;

  typedef struct packed {
    logic [CFG_W-1:0] hue_low;
    logic [CFG_W-1:0] hue_high;
    logic [CFG_W-1:0] hue_shift;
  } cfg_t;

endpackage

// ----- hw/rtl/rhrs_front.sv -----
// ----------------------------------------------------------------------------
// rhrs_front
// Two stages: max/min and sector select, then the hue and saturation
// dividends for the pipelined divider.
// ----------------------------------------------------------------------------
module rhrs_front #(
  parameter int unsigned HUE_FRAC_BITS = 4,
  parameter int unsigned DW            = 18
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [rhrs_pkg::PIX_W-1:0]  red_i,
  input  logic [rhrs_pkg::PIX_W-1:0]  green_i,
  input  logic [rhrs_pkg::PIX_W-1:0]  blue_i,
  output logic                        valid_o,
  output rhrs_pkg::side_t             side_o,
  output logic [DW-1:0]               hue_dvd_o,
  output logic [rhrs_pkg::PIX_W-1:0]  hue_dvs_o,
  output logic [DW-1:0]               sat_dvd_o,
  output logic [rhrs_pkg::PIX_W-1:0]  sat_dvs_o
);

  localparam int unsigned PW = rhrs_pkg::PIX_W;

  // stage A
  logic [PW-1:0]   mx, mn, op_a, op_b, mag;
  logic [PW:0]     diff;
  rhrs_pkg::side_t side_d;
  logic            va_q;
  rhrs_pkg::side_t side_a_q;
  logic [PW-1:0]   mag_a_q, c_a_q;

  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;

    if (blue_i == mx) begin
      side_d.sector = rhrs_pkg::SEC_BLUE;
      op_a = red_i;
      op_b = green_i;
    end else if (green_i == mx) begin
      side_d.sector = rhrs_pkg::SEC_GREEN;
      op_a = blue_i;
      op_b = red_i;
    end else begin
      side_d.sector = rhrs_pkg::SEC_RED;
      op_a = green_i;
      op_b = blue_i;
    end

    diff = {1'b0, op_a} - {1'b0, op_b};
    mag  = diff[PW] ? PW'(-diff) : diff[PW-1:0];

    side_d.mx      = mx;
    side_d.neg     = diff[PW];
    side_d.c_zero  = (mx == mn);
    side_d.mx_zero = (mx == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_a_q <= side_d;
      mag_a_q  <= mag;
      c_a_q    <= mx - mn;
    end
  end

  // stage B: 60 * |num| scaled to fixed point, and c * 256
  logic [13:0] prod;
  assign prod = 14'(mag_a_q) * 14'd60;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o    <= side_a_q;
      hue_dvd_o <= DW'(prod) << HUE_FRAC_BITS;
      hue_dvs_o <= c_a_q;
      sat_dvd_o <= DW'({c_a_q, 8'd0});
      sat_dvs_o <= side_a_q.mx;
    end
  end

endmodule

// ----- hw/rtl/rhrs_div.sv -----
// ----------------------------------------------------------------------------
// rhrs_div
// Two-lane restoring divider, one quotient bit per stage, QW stages.
// Both quotients must fit in QW bits.
// ----------------------------------------------------------------------------
module rhrs_div #(
  parameter int unsigned QW = 10,
  parameter int unsigned DW = 18
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  rhrs_pkg::side_t             side_i,
  input  logic [DW-1:0]               hue_dvd_i,
  input  logic [rhrs_pkg::PIX_W-1:0]  hue_dvs_i,
  input  logic [DW-1:0]               sat_dvd_i,
  input  logic [rhrs_pkg::PIX_W-1:0]  sat_dvs_i,
  output logic                        valid_o,
  output rhrs_pkg::side_t             side_o,
  output logic [QW-1:0]               hue_quo_o,
  output logic [QW-1:0]               sat_quo_o
);

  localparam int unsigned PW = rhrs_pkg::PIX_W;

  logic                vld_q  [QW];
  rhrs_pkg::side_t     side_q [QW];
  logic [DW-1:0]       hrem_q [QW];
  logic [DW-1:0]       srem_q [QW];
  logic [PW-1:0]       hdvs_q [QW];
  logic [PW-1:0]       sdvs_q [QW];
  logic [QW-1:0]       hquo_q [QW];
  logic [QW-1:0]       squo_q [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    localparam int unsigned K = QW - 1 - i;

    logic            vld_in;
    rhrs_pkg::side_t side_in;
    logic [DW-1:0]   hrem_in, srem_in, htrial, strial;
    logic [PW-1:0]   hdvs_in, sdvs_in;
    logic [QW-1:0]   hquo_in, squo_in;
    logic            hbit, sbit;

    if (i == 0) begin : g_first
      assign vld_in  = valid_i;
      assign side_in = side_i;
      assign hrem_in = hue_dvd_i;
      assign srem_in = sat_dvd_i;
      assign hdvs_in = hue_dvs_i;
      assign sdvs_in = sat_dvs_i;
      assign hquo_in = '0;
      assign squo_in = '0;
    end else begin : g_next
      assign vld_in  = vld_q[i-1];
      assign side_in = side_q[i-1];
      assign hrem_in = hrem_q[i-1];
      assign srem_in = srem_q[i-1];
      assign hdvs_in = hdvs_q[i-1];
      assign sdvs_in = sdvs_q[i-1];
      assign hquo_in = hquo_q[i-1];
      assign squo_in = squo_q[i-1];
    end

    assign htrial = DW'(hdvs_in) << K;
    assign strial = DW'(sdvs_in) << K;
    assign hbit   = (hrem_in >= htrial);
    assign sbit   = (srem_in >= strial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[i] <= side_in;
        hrem_q[i] <= hbit ? hrem_in - htrial : hrem_in;
        srem_q[i] <= sbit ? srem_in - strial : srem_in;
        hdvs_q[i] <= hdvs_in;
        sdvs_q[i] <= sdvs_in;
        hquo_q[i] <= hquo_in | (QW'(hbit) << K);
        squo_q[i] <= squo_in | (QW'(sbit) << K);
      end
    end
  end

  assign valid_o   = vld_q[QW-1];
  assign side_o    = side_q[QW-1];
  assign hue_quo_o = hquo_q[QW-1];
  assign sat_quo_o = squo_q[QW-1];

endmodule

// ----- hw/rtl/rhrs_back.sv -----
// ----------------------------------------------------------------------------
// rhrs_back
// Three stages: hue from sector and quotient, range check and shift,
// full-turn wrap into the output register.
// ----------------------------------------------------------------------------
module rhrs_back #(
  parameter int unsigned HUE_FRAC_BITS = 4,
  parameter int unsigned QW            = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  rhrs_pkg::side_t             side_i,
  input  logic [QW-1:0]               hue_quo_i,
  input  logic [QW-1:0]               sat_quo_i,
  input  rhrs_pkg::cfg_t              cfg_i,
  output logic                        valid_o,
  output logic [rhrs_pkg::HUE_W-1:0]  hue_o,
  output logic                        in_range_o,
  output logic [rhrs_pkg::SAT_W-1:0]  saturation_o,
  output logic [rhrs_pkg::PIX_W-1:0]  brightness_o
);

  localparam int unsigned PW   = rhrs_pkg::PIX_W;
  localparam int unsigned SW   = rhrs_pkg::SAT_W;
  localparam int unsigned OW   = rhrs_pkg::HUE_W;
  localparam int unsigned HW   = 10 + HUE_FRAC_BITS;
  localparam int unsigned EXTW = (HW > OW) ? HW : OW;

  localparam logic [HW-1:0] S2  = HW'(120 << HUE_FRAC_BITS);
  localparam logic [HW-1:0] S4  = HW'(240 << HUE_FRAC_BITS);
  localparam logic [HW-1:0] FT  = HW'(360 << HUE_FRAC_BITS);
  localparam logic [HW-1:0] FT2 = HW'(720 << HUE_FRAC_BITS);

  // stage 1: signed quotient around the sector base
  logic [HW-1:0] qh, h_d;
  logic          v1_q;
  logic [HW-1:0] h1_q;
  logic [SW-1:0] s1_q;
  logic [PW-1:0] m1_q;

  assign qh = HW'(hue_quo_i);

  always_comb begin
    case (side_i.sector)
      rhrs_pkg::SEC_BLUE:  h_d = side_i.neg ? S4 - qh : S4 + qh;
      rhrs_pkg::SEC_GREEN: h_d = side_i.neg ? S2 - qh : S2 + qh;
      rhrs_pkg::SEC_RED:   h_d = (side_i.neg && qh != '0) ? FT - qh : qh;
      default:             h_d = '0;
    endcase
    if (side_i.c_zero) h_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h1_q <= h_d;
      s1_q <= side_i.mx_zero ? '0 : sat_quo_i[SW-1:0];
      m1_q <= side_i.mx;
    end
  end

  // stage 2: inclusive range compare, add shift
  logic [HW-1:0] lo, hi, sh;
  logic          inr;
  logic          v2_q, r2_q;
  logic [HW-1:0] h2_q;
  logic [SW-1:0] s2_q;
  logic [PW-1:0] m2_q;

  assign lo  = HW'(cfg_i.hue_low) << HUE_FRAC_BITS;
  assign hi  = HW'(cfg_i.hue_high) << HUE_FRAC_BITS;
  assign sh  = HW'(cfg_i.hue_shift) << HUE_FRAC_BITS;
  assign inr = (h1_q >= lo) && (h1_q <= hi);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r2_q <= inr;
      h2_q <= inr ? h1_q + sh : '0;
      s2_q <= s1_q;
      m2_q <= m1_q;
    end
  end

  // stage 3: drop whole turns above a full turn; exactly a full turn stays
  logic [HW-1:0]   hw_d;
  logic [EXTW-1:0] hext;

  always_comb begin
    if (h2_q <= FT) begin
      hw_d = h2_q;
    end else if (h2_q < FT2) begin
      hw_d = h2_q - FT;
    end else begin
      hw_d = h2_q - FT2;
    end
  end

  assign hext = EXTW'(hw_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hue_o        <= hext[OW-1:0];
      in_range_o   <= r2_q;
      saturation_o <= s2_q;
      brightness_o <= m2_q;
    end
  end

endmodule

// ----- hw/rtl/rgb_hue_range_shift.sv -----
// ----------------------------------------------------------------------------
// rgb_hue_range_shift
// Divider quotient width Q = max(9, bits of 60 * 2^HUE_FRAC_BITS).
// Throughput: one pixel per cycle unless the output is held; the divider retires one quotient bit per stage.
// The whole pipeline holds while the output item waits and the sink is not ready.
// Reset clears all valid bits and loads hue_low 0, hue_high 360, hue_shift 0.
// ----------------------------------------------------------------------------
module rgb_hue_range_shift #(
  parameter int unsigned HUE_FRAC_BITS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i,
  // pixel in
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [23:0] s_tdata_i,   // red [7:0], green [15:8], blue [23:16]
  // result out
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [31:0] m_tdata_o,   // hue [12:0], saturation [21:13], brightness [29:22]
  output logic        m_tuser_o    // in_range [0]
);

  localparam int unsigned PW    = rhrs_pkg::PIX_W;
  localparam int unsigned DEG_S = 60 << HUE_FRAC_BITS;
  localparam int unsigned HQW   = $clog2(DEG_S + 1);
  localparam int unsigned QW    = (HQW > 9) ? HQW : 9;
  localparam int unsigned DW    = QW + 8;

  rhrs_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hue_low   <= rhrs_pkg::HUE_LOW_RST;
      cfg_q.hue_high  <= rhrs_pkg::HUE_HIGH_RST;
      cfg_q.hue_shift <= rhrs_pkg::HUE_SHIFT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rhrs_pkg::CFG_HUE_LOW:   cfg_q.hue_low   <= cfg_data_i;
        rhrs_pkg::CFG_HUE_HIGH:  cfg_q.hue_high  <= cfg_data_i;
        rhrs_pkg::CFG_HUE_SHIFT: cfg_q.hue_shift <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // advance every stage unless the output item is held
  logic en;
  assign en         = !m_tvalid_o || m_tready_i;
  assign s_tready_o = en;

  logic            f_valid;
  rhrs_pkg::side_t f_side;
  logic [DW-1:0]   f_hdvd, f_sdvd;
  logic [PW-1:0]   f_hdvs, f_sdvs;

  rhrs_front #(
    .HUE_FRAC_BITS (HUE_FRAC_BITS),
    .DW            (DW)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (s_tvalid_i),
    .red_i     (s_tdata_i[7:0]),
    .green_i   (s_tdata_i[15:8]),
    .blue_i    (s_tdata_i[23:16]),
    .valid_o   (f_valid),
    .side_o    (f_side),
    .hue_dvd_o (f_hdvd),
    .hue_dvs_o (f_hdvs),
    .sat_dvd_o (f_sdvd),
    .sat_dvs_o (f_sdvs)
  );

  logic            d_valid;
  rhrs_pkg::side_t d_side;
  logic [QW-1:0]   d_hquo, d_squo;

  rhrs_div #(
    .QW (QW),
    .DW (DW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (f_valid),
    .side_i    (f_side),
    .hue_dvd_i (f_hdvd),
    .hue_dvs_i (f_hdvs),
    .sat_dvd_i (f_sdvd),
    .sat_dvs_i (f_sdvs),
    .valid_o   (d_valid),
    .side_o    (d_side),
    .hue_quo_o (d_hquo),
    .sat_quo_o (d_squo)
  );

  logic [rhrs_pkg::HUE_W-1:0] hue;
  logic [rhrs_pkg::SAT_W-1:0] sat;
  logic [PW-1:0]              bright;
  logic                       in_range;

  rhrs_back #(
    .HUE_FRAC_BITS (HUE_FRAC_BITS),
    .QW            (QW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (d_valid),
    .side_i       (d_side),
    .hue_quo_i    (d_hquo),
    .sat_quo_i    (d_squo),
    .cfg_i        (cfg_q),
    .valid_o      (m_tvalid_o),
    .hue_o        (hue),
    .in_range_o   (in_range),
    .saturation_o (sat),
    .brightness_o (bright)
  );

  assign m_tdata_o = {2'b00, bright, sat, hue};
  assign m_tuser_o = in_range;

  // an item outside the band carries no hue
  a_out_of_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !in_range |-> hue == '0)
    else $error("out-of-range item with nonzero hue");

  a_sat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> sat <= 9'd256)
    else $error("saturation above 256");

  a_black_no_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && bright == '0 |-> sat == '0)
    else $error("black pixel with nonzero saturation");

endmodule

// ----- verif/rgb_hue_range_shift_tb.sv -----
// ----------------------------------------------------------------------------
// rgb_hue_range_shift_tb
// Streams RGB pixels through the hue range shifter and checks hue, in-range
// flag, saturation and brightness of every result against a behavioral
// RGB-to-HSV predictor. The run covers several hue bands and shifts, random
// stalls on both sides and one long sink hold-off.
// ----------------------------------------------------------------------------
module rgb_hue_range_shift_tb;

  localparam int FRAC_BITS    = 4;
  localparam int SECTOR       = 60 << FRAC_BITS;
  localparam int TURN         = 360 << FRAC_BITS;
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES  = 80;

  typedef struct packed {
    logic [rhrs_pkg::HUE_W-1:0] hue;
    logic                       in_range;
    logic [rhrs_pkg::SAT_W-1:0] sat;
    logic [rhrs_pkg::PIX_W-1:0] bright;
  } hsv_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [8:0]  cfg_data_i;
  logic        s_tvalid_i;
  logic        s_tready_o;
  logic [23:0] s_tdata_i;   // red [7:0], green [15:8], blue [23:16]
  logic        m_tvalid_o;
  logic        m_tready_i;
  logic [31:0] m_tdata_o;   // hue [12:0], saturation [21:13], brightness [29:22]
  logic        m_tuser_o;   // in_range [0]

  logic [rhrs_pkg::CFG_W-1:0] band_low;
  logic [rhrs_pkg::CFG_W-1:0] band_high;
  logic [rhrs_pkg::CFG_W-1:0] band_shift;

  hsv_t hsv_expected[$];
  int   errors = 0;
  bit   src_idle_en;
  bit   sink_idle_en;
  int   hold_req = 0;

  rgb_hue_range_shift #(
    .HUE_FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic hsv_t predict_hsv(logic [7:0] r8, logic [7:0] g8, logic [7:0] b8);
    int          r, g, b, mx, mn, c, h;
    int unsigned hu, lo, hi;
    hsv_t        res;
    r  = int'(r8);
    g  = int'(g8);
    b  = int'(b8);
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    c = mx - mn;
    h = 0;
    // blue wins every tie, then green; signed division truncates toward zero
    if (c != 0) begin
      if (b == mx) begin
        h = 4 * SECTOR + (SECTOR * (r - g)) / c;
      end else if (g == mx) begin
        h = 2 * SECTOR + (SECTOR * (b - r)) / c;
      end else begin
        h = (SECTOR * (g - b)) / c;
        if (h < 0) h += TURN;
        if (h == TURN) h = 0;
      end
    end
    hu = h;
    lo = int'(band_low) << FRAC_BITS;
    hi = int'(band_high) << FRAC_BITS;
    res.in_range = (hu >= lo) && (hu <= hi);
    if (res.in_range) begin
      hu += int'(band_shift) << FRAC_BITS;
      if (hu > TURN) hu = hu % TURN;
    end else begin
      hu = 0;
    end
    res.hue    = hu[rhrs_pkg::HUE_W-1:0];
    res.sat    = (mx == 0) ? '0 : rhrs_pkg::SAT_W'((c * 256) / mx);
    res.bright = mx[rhrs_pkg::PIX_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  task automatic enqueue_expected(hsv_t item);
    hsv_expected = {hsv_expected, item};
  endtask

  // mix of plain random, near-gray, tied channels and saturated channels
  function automatic logic [23:0] random_pixel();
    logic [7:0] ch[3];
    int         base, k;
    case ($urandom_range(0, 5))
      1: begin
        base = $urandom_range(0, 255);
        for (k = 0; k < 3; k++) begin
          ch[k] = (base + $urandom_range(0, 3) > 255) ? 8'd255 : 8'(base + $urandom_range(0, 3));
        end
      end
      2: begin
        base = $urandom_range(0, 255);
        k = $urandom_range(0, 2);
        ch[0] = 8'(base);
        ch[1] = 8'(base);
        ch[2] = 8'(base);
        ch[k] = 8'($urandom_range(0, 255));
      end
      3: begin
        for (k = 0; k < 3; k++) begin
          case ($urandom_range(0, 2))
            0: ch[k] = 8'd0;
            1: ch[k] = 8'd255;
            default: ch[k] = 8'($urandom_range(0, 255));
          endcase
        end
      end
      default: begin
        for (k = 0; k < 3; k++) ch[k] = 8'($urandom_range(0, 255));
      end
    endcase
    return {ch[2], ch[1], ch[0]};
  endfunction

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int gap;
    gap = (src_idle_en && $urandom_range(0, 5) == 0) ? $urandom_range(1, 14) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      s_tvalid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= {b, g, r};
    do @(posedge clk_i); while (!s_tready_o);
    enqueue_expected(predict_hsv(r, g, b));
  endtask

  task automatic send_random(int n);
    logic [23:0] px;
    repeat (n) begin
      px = random_pixel();
      send_pixel(px[7:0], px[15:8], px[23:16]);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_tvalid_i <= 1'b0;
    while (hsv_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [rhrs_pkg::IDX_W-1:0] idx,
                           logic [rhrs_pkg::CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    case (idx)
      rhrs_pkg::CFG_HUE_LOW:  band_low   = value;
      rhrs_pkg::CFG_HUE_HIGH: band_high  = value;
      default:                band_shift = value;
    endcase
  endtask

  task automatic set_band(logic [rhrs_pkg::CFG_W-1:0] lo, logic [rhrs_pkg::CFG_W-1:0] hi,
                          logic [rhrs_pkg::CFG_W-1:0] sh);
    write_reg(rhrs_pkg::CFG_HUE_LOW, lo);
    write_reg(rhrs_pkg::CFG_HUE_HIGH, hi);
    write_reg(rhrs_pkg::CFG_HUE_SHIFT, sh);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // reset band: extremes of each channel, every sector, ties and truncation
  task automatic test_directed();
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd255, 8'd0,   8'd10);
    send_pixel(8'd200, 8'd1,   8'd0);
    send_pixel(8'd0,   8'd5,   8'd7);
    send_pixel(8'd7,   8'd9,   8'd0);
    send_pixel(8'd1,   8'd0,   8'd0);
    send_pixel(8'd0,   8'd1,   8'd0);
    send_pixel(8'd0,   8'd0,   8'd1);
    send_pixel(8'd1,   8'd1,   8'd2);
    send_pixel(8'd254, 8'd255, 8'd253);
    send_pixel(8'd170, 8'd85,  8'd255);
    send_pixel(8'd255, 8'd128, 8'd0);
    send_pixel(8'd100, 8'd255, 8'd99);
    drain();
  endtask

  task automatic test_band(logic [rhrs_pkg::CFG_W-1:0] lo, logic [rhrs_pkg::CFG_W-1:0] hi,
                           logic [rhrs_pkg::CFG_W-1:0] sh, int n);
    set_band(lo, hi, sh);
    send_pixel(8'd90,  8'd90,  8'd90);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd1);
    send_random(n);
    drain();
  endtask

  // stop the sink long enough for the pipeline to fill and stall the source
  task automatic test_backpressure();
    src_idle_en = 1'b0;
    hold_req++;
    send_random(50);
    drain();
    src_idle_en = 1'b1;
  endtask

  task automatic test_steady();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    set_band(rhrs_pkg::CFG_W'($urandom_range(0, 200)), rhrs_pkg::CFG_W'($urandom_range(150, 360)),
             rhrs_pkg::CFG_W'($urandom_range(0, 360)));
    send_random(100);
    drain();
  endtask

  initial begin : sink
    int stall;
    int hold_done;
    hold_done  = 0;
    m_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req != hold_done) begin
        m_tready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_done = hold_req;
      end else if (sink_idle_en && $urandom_range(0, 6) == 0) begin
        stall = $urandom_range(1, 14);
        m_tready_i <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end else begin
        m_tready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    hsv_t want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (hsv_expected.size() == 0) begin
        report_mismatch("unexpected result, tdata", int'(m_tdata_o), 0);
      end else begin
        want = hsv_expected.pop_front();
        if (m_tdata_o[12:0] !== want.hue)
          report_mismatch("hue", int'(m_tdata_o[12:0]), int'(want.hue));
        if (m_tuser_o !== want.in_range)
          report_mismatch("in_range", int'(m_tuser_o), int'(want.in_range));
        if (m_tdata_o[21:13] !== want.sat)
          report_mismatch("saturation", int'(m_tdata_o[21:13]), int'(want.sat));
        if (m_tdata_o[29:22] !== want.bright)
          report_mismatch("brightness", int'(m_tdata_o[29:22]), int'(want.bright));
        if (m_tdata_o[31:30] !== 2'b00)
          report_mismatch("tdata pad", int'(m_tdata_o[31:30]), 0);
      end
    end
  end

  initial begin : watchdog
    #6000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : run
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = rhrs_pkg::CFG_HUE_LOW;
    cfg_data_i   = '0;
    s_tvalid_i   = 1'b0;
    s_tdata_i    = '0;
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    band_low     = rhrs_pkg::HUE_LOW_RST;
    band_high    = rhrs_pkg::HUE_HIGH_RST;
    band_shift   = rhrs_pkg::HUE_SHIFT_RST;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_band(9'd0,   9'd360, 9'd360, 110);
    test_band(9'd100, 9'd200, 9'd90,  110);
    test_band(9'd200, 9'd100, 9'd0,   110);
    test_band(9'd511, 9'd511, 9'd511, 110);
    test_band(9'd0,   9'd0,   9'd180, 110);
    test_band(9'd360, 9'd360, 9'd45,  110);
    test_band(9'd60,  9'd180, 9'd300, 110);
    test_backpressure();
    test_band(rhrs_pkg::CFG_W'($urandom_range(0, 360)), rhrs_pkg::CFG_W'($urandom_range(0, 511)),
              rhrs_pkg::CFG_W'($urandom_range(0, 511)), 110);
    test_steady();

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/rhrs_pkg.sv
hw/rtl/rhrs_front.sv
hw/rtl/rhrs_div.sv
hw/rtl/rhrs_back.sv
hw/rtl/rgb_hue_range_shift.sv
verif/rgb_hue_range_shift_tb.sv
